// ===== sv/spectrum_bin_slew_smoother_defines.svh =====
// Assertion macros shared by the spectrum bin slew smoother RTL.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef SPECTRUM_BIN_SLEW_SMOOTHER_DEFINES_SVH
`define SPECTRUM_BIN_SLEW_SMOOTHER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held
`define SBSS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held
`define SBSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/sbss_pkg.sv =====
// Shared types, widths and register codes for the spectrum bin slew smoother.
// No dependencies; used by every module of the block.
package sbss_pkg;

  // Field widths
  localparam int BinW    = 9;
  localparam int LevelW  = 24;
  localparam int SlopeW  = 25;
  localparam int ElapW   = 16;
  localparam int RateW   = 24;
  localparam int RateSh  = 12;
  localparam int ProdW   = ElapW + RateW;
  localparam int LimW    = ProdW - RateSh;
  localparam int BoundW  = LimW + 2;
  localparam int CfgIdxW = 2;

  // Stream payload widths, padded to whole bytes
  localparam int InDataW  = 56;
  localparam int OutDataW = 64;

  localparam int NumBinsDefault = 512;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgRiseRate  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgFallRate  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgAccelRate = 2'd2;

  localparam logic [RateW-1:0] RateReset = {RateW{1'b1}};
  localparam logic [LevelW-1:0] LevelMax = {LevelW{1'b1}};

  // One memory word: per-bin slope and smoothed level
  typedef struct packed {
    logic signed [SlopeW-1:0] slope;
    logic [LevelW-1:0]        level;
  } state_t;

  // Per-item limits handed from the limit stage to the apply stage
  typedef struct packed {
    logic                     rising;
    logic [LevelW-1:0]        cand;
    logic signed [BoundW-1:0] bound;
  } limit_t;

endpackage

// ===== sv/spectrum_bin_slew_smoother.sv =====
// Spectrum bin slew smoother top level: stream pipeline around the state memory.
// Depends on sbss_pkg, sbss_state_mem, sbss_rate_mul, sbss_limit_calc, defines.
//
//  Channel  | Dir | Request fields
//  ---------+-----+-----------------------------------------------------------
//  s_axis   | in  | tdata: bin_index, magnitude, elapsed_samples; tuser: first_frame
//  m_axis   | out | tdata: out_bin, level, slope
//  cfg      | in  | cfg_index_i (0 rise, 1 fall, 2 accel), cfg_data_i
//
// One bin per cycle unless m_axis stalls; results pass B, C and the output register.
// Two requests for the same bin in consecutive cycles hold the second in stage B:
// the read-modify-write loop closes through the slope/level apply stage.
// After reset a clearing pass writes zero to all NUM_BINS entries, one per
// cycle, with s_axis_tready_o low; configuration writes are taken throughout.
// First-frame requests and bins at or above NUM_BINS are taken and dropped.
`include "spectrum_bin_slew_smoother_defines.svh"

module spectrum_bin_slew_smoother #(
  parameter int NUM_BINS = sbss_pkg::NumBinsDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // bin_index [8:0], magnitude [32:9], elapsed_samples [48:33], zero pad
  input  logic [sbss_pkg::InDataW-1:0]      s_axis_tdata_i,
  // first_frame [0]
  input  logic                              s_axis_tuser_i,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // out_bin [8:0], level [32:9], slope [57:33], zero pad
  output logic [sbss_pkg::OutDataW-1:0]     m_axis_tdata_o,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [sbss_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [sbss_pkg::RateW-1:0]        cfg_data_i
);

  localparam int AddrW = $clog2(NUM_BINS);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(NUM_BINS - 1);
  localparam logic [31:0] NumBins32 = 32'(NUM_BINS);

  // Input field unpacking
  logic [sbss_pkg::BinW-1:0]   in_bin;
  logic [sbss_pkg::LevelW-1:0] in_mag;
  logic [sbss_pkg::ElapW-1:0]  in_elapsed;
  logic                        in_keep;
  logic                        in_fire;

  assign in_bin     = s_axis_tdata_i[8:0];
  assign in_mag     = s_axis_tdata_i[32:9];
  assign in_elapsed = s_axis_tdata_i[48:33];
  assign in_keep    = !s_axis_tuser_i && ({23'd0, in_bin} < NumBins32);

  // Configuration registers
  logic [sbss_pkg::RateW-1:0] rise_rate_q, fall_rate_q, accel_rate_q;
  logic                       cfg_fire;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rise_rate_q  <= sbss_pkg::RateReset;
      fall_rate_q  <= sbss_pkg::RateReset;
      accel_rate_q <= sbss_pkg::RateReset;
    end else if (cfg_fire) begin
      unique case (cfg_index_i)
        sbss_pkg::CfgRiseRate:  rise_rate_q  <= cfg_data_i;
        sbss_pkg::CfgFallRate:  fall_rate_q  <= cfg_data_i;
        sbss_pkg::CfgAccelRate: accel_rate_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clearing pass after reset
  logic             clr_busy_q, clr_busy_d;
  logic [AddrW-1:0] clr_addr_q, clr_addr_d;

  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_addr_d = clr_addr_q;
    if (clr_busy_q) begin
      clr_addr_d = clr_addr_q + AddrW'(1);
      if (clr_addr_q == LastAddr) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  // Pipeline control
  logic             b_valid_q, b_valid_d;
  logic             c_valid_q, c_valid_d;
  logic             m_valid_q, m_valid_d;
  logic [AddrW-1:0] b_addr_q, c_addr_q;
  logic             hazard, b_adv, c_adv;

  assign c_adv  = !m_valid_q || m_axis_tready_i;
  assign hazard = b_valid_q && c_valid_q && (b_addr_q == c_addr_q);
  assign b_adv  = !hazard && (!c_valid_q || c_adv);

  assign s_axis_tready_o = !clr_busy_q && (!b_valid_q || b_adv);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    b_valid_d = b_valid_q;
    if (in_fire) begin
      b_valid_d = in_keep;
    end else if (b_adv) begin
      b_valid_d = 1'b0;
    end
    c_valid_d = c_valid_q;
    if (!c_valid_q || c_adv) begin
      c_valid_d = b_valid_q && !hazard;
    end
    m_valid_d = m_valid_q;
    if (c_adv) begin
      m_valid_d = c_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      b_valid_q <= b_valid_d;
      c_valid_q <= c_valid_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Stage B payload: captured on each accepted request
  logic [sbss_pkg::BinW-1:0]   b_bin_q;
  logic [sbss_pkg::LevelW-1:0] b_mag_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      b_bin_q  <= in_bin;
      b_addr_q <= AddrW'(in_bin);
      b_mag_q  <= in_mag;
    end
  end

  // Rate limits, ready in stage B
  logic [sbss_pkg::LimW-1:0] rise_lim, fall_lim, acc_lim;

  sbss_rate_mul u_rate_mul (
    .clk_i        (clk_i),
    .en_i         (in_fire),
    .elapsed_i    (in_elapsed),
    .rise_rate_i  (rise_rate_q),
    .fall_rate_i  (fall_rate_q),
    .accel_rate_i (accel_rate_q),
    .rise_lim_o   (rise_lim),
    .fall_lim_o   (fall_lim),
    .acc_lim_o    (acc_lim)
  );

  // State memory: clearing pass or stage C write-back
  sbss_pkg::state_t  wr_state, rd_state, b_state;
  logic              mem_we, c_fire;
  logic [AddrW-1:0]  mem_waddr;
  sbss_pkg::state_t  mem_wdata;

  assign c_fire    = c_valid_q && c_adv;
  assign mem_we    = clr_busy_q || c_fire;
  assign mem_waddr = clr_busy_q ? clr_addr_q : c_addr_q;
  assign mem_wdata = clr_busy_q ? '0 : wr_state;

  sbss_state_mem #(
    .Depth (NUM_BINS)
  ) u_state_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (in_fire),
    .raddr_i (AddrW'(in_bin)),
    .rdata_o (rd_state)
  );

  // Last write-back, forwarded over a read taken at the same edge
  logic             last_valid_q;
  logic [AddrW-1:0] last_addr_q;
  sbss_pkg::state_t last_state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_valid_q <= 1'b0;
    end else if (c_fire) begin
      last_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_fire) begin
      last_addr_q  <= c_addr_q;
      last_state_q <= wr_state;
    end
  end

  assign b_state = (last_valid_q && last_addr_q == b_addr_q) ? last_state_q : rd_state;

  // Stage B: step and slope bound
  sbss_pkg::limit_t b_lim;

  sbss_limit_calc u_limit_calc (
    .mag_i      (b_mag_q),
    .state_i    (b_state),
    .rise_lim_i (rise_lim),
    .fall_lim_i (fall_lim),
    .acc_lim_i  (acc_lim),
    .lim_o      (b_lim)
  );

  // Stage C payload
  logic [sbss_pkg::BinW-1:0]   c_bin_q;
  logic [sbss_pkg::LevelW-1:0] c_lvl_q;
  sbss_pkg::limit_t            c_lim_q;

  always_ff @(posedge clk_i) begin
    if (b_valid_q && b_adv) begin
      c_bin_q  <= b_bin_q;
      c_addr_q <= b_addr_q;
      c_lvl_q  <= b_state.level;
      c_lim_q  <= b_lim;
    end
  end

  // Stage C: apply the acceleration bound, then move and clamp the level
  logic signed [sbss_pkg::BoundW-1:0] cand_x, neg_cand, change_x;
  logic signed [sbss_pkg::SlopeW-1:0] change;
  logic signed [sbss_pkg::LevelW+1:0] sum;
  logic [sbss_pkg::LevelW-1:0]        next_lvl;

  assign cand_x   = signed'({6'd0, c_lim_q.cand});
  assign neg_cand = -cand_x;

  always_comb begin
    if (c_lim_q.rising) begin
      change_x = (c_lim_q.bound < cand_x) ? c_lim_q.bound : cand_x;
    end else begin
      change_x = (c_lim_q.bound > neg_cand) ? c_lim_q.bound : neg_cand;
    end
  end

  assign change = change_x[sbss_pkg::SlopeW-1:0];
  assign sum    = signed'({2'b00, c_lvl_q}) + (sbss_pkg::LevelW + 2)'(change);

  always_comb begin
    if (sum[sbss_pkg::LevelW+1]) begin
      next_lvl = '0;
    end else if (sum[sbss_pkg::LevelW]) begin
      next_lvl = sbss_pkg::LevelMax;
    end else begin
      next_lvl = sum[sbss_pkg::LevelW-1:0];
    end
  end

  assign wr_state.slope = change;
  assign wr_state.level = next_lvl;

  // Output register
  logic [sbss_pkg::BinW-1:0]   out_bin_q;
  logic [sbss_pkg::LevelW-1:0] out_level_q;
  logic [sbss_pkg::SlopeW-1:0] out_slope_q;

  always_ff @(posedge clk_i) begin
    if (c_fire) begin
      out_bin_q   <= c_bin_q;
      out_level_q <= next_lvl;
      out_slope_q <= change;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {6'd0, out_slope_q, out_level_q, out_bin_q};

  // Checks
  `SBSS_ASSERT_NOW(a_no_accept_in_clear, clr_busy_q, !s_axis_tready_o, "request taken during clear")
  `SBSS_ASSERT_NEXT(a_clear_ends, clr_busy_q && clr_addr_q == LastAddr, !clr_busy_q, "clear overran")
  `SBSS_ASSERT_NOW(a_hazard_holds_b, hazard, !b_adv, "same-bin request passed unfinished update")
  `SBSS_ASSERT_NEXT(a_write_forwarded, c_fire, last_valid_q && last_addr_q == $past(c_addr_q), "write-back not tracked")
  `SBSS_ASSERT_NEXT(a_result_shown, c_fire, m_axis_tvalid_o, "result lost at output register")

endmodule

// ===== sv/sbss_state_mem.sv =====
// Per-bin state memory: one write port, one read port with registered data.
// Depends on sbss_pkg for the state word type.
module sbss_state_mem #(
  parameter int Depth = sbss_pkg::NumBinsDefault,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrW-1:0]     waddr_i,
  input  sbss_pkg::state_t     wdata_i,
  input  logic                 re_i,
  input  logic [AddrW-1:0]     raddr_i,
  output sbss_pkg::state_t     rdata_o
);

  sbss_pkg::state_t mem_q [Depth];
  sbss_pkg::state_t rdata_q;

  // Write the addressed entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read; old data on a same-edge write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/sbss_rate_mul.sv =====
// Rate limit multipliers: elapsed samples times each rate, shifted down.
// Depends on sbss_pkg for widths; results are registered on each request.
module sbss_rate_mul (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic [sbss_pkg::ElapW-1:0]       elapsed_i,
  input  logic [sbss_pkg::RateW-1:0]       rise_rate_i,
  input  logic [sbss_pkg::RateW-1:0]       fall_rate_i,
  input  logic [sbss_pkg::RateW-1:0]       accel_rate_i,
  output logic [sbss_pkg::LimW-1:0]        rise_lim_o,
  output logic [sbss_pkg::LimW-1:0]        fall_lim_o,
  output logic [sbss_pkg::LimW-1:0]        acc_lim_o
);

  logic [sbss_pkg::ProdW-1:0] rise_prod, fall_prod, acc_prod;
  logic [sbss_pkg::LimW-1:0]  rise_lim_q, fall_lim_q, acc_lim_q;

  // Three independent 16x24 products
  assign rise_prod = sbss_pkg::ProdW'(elapsed_i) * sbss_pkg::ProdW'(rise_rate_i);
  assign fall_prod = sbss_pkg::ProdW'(elapsed_i) * sbss_pkg::ProdW'(fall_rate_i);
  assign acc_prod  = sbss_pkg::ProdW'(elapsed_i) * sbss_pkg::ProdW'(accel_rate_i);

  // Drop the fraction bits and hold until the next request
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rise_lim_q <= rise_prod[sbss_pkg::ProdW-1:sbss_pkg::RateSh];
      fall_lim_q <= fall_prod[sbss_pkg::ProdW-1:sbss_pkg::RateSh];
      acc_lim_q  <= acc_prod[sbss_pkg::ProdW-1:sbss_pkg::RateSh];
    end
  end

  assign rise_lim_o = rise_lim_q;
  assign fall_lim_o = fall_lim_q;
  assign acc_lim_o  = acc_lim_q;

endmodule

// ===== sv/sbss_limit_calc.sv =====
// Limit stage: direction, step toward the target and the acceleration bound.
// Depends on sbss_pkg for widths and the limit_t handoff struct.
module sbss_limit_calc (
  input  logic [sbss_pkg::LevelW-1:0]        mag_i,
  input  sbss_pkg::state_t                   state_i,
  input  logic [sbss_pkg::LimW-1:0]          rise_lim_i,
  input  logic [sbss_pkg::LimW-1:0]          fall_lim_i,
  input  logic [sbss_pkg::LimW-1:0]          acc_lim_i,
  output sbss_pkg::limit_t                   lim_o
);

  logic                               rising;
  logic [sbss_pkg::LevelW-1:0]        diff;
  logic [sbss_pkg::LimW-1:0]          lim;
  logic signed [sbss_pkg::BoundW-1:0] old_x;
  logic signed [sbss_pkg::BoundW-1:0] acc_x;

  // Direction and distance to the new magnitude
  assign rising = mag_i > state_i.level;
  assign diff   = rising ? (mag_i - state_i.level) : (state_i.level - mag_i);
  assign lim    = rising ? rise_lim_i : fall_lim_i;

  // Clip the step to the rate limit; a smaller limit always fits the level width
  assign lim_o.rising = rising;
  assign lim_o.cand   = (lim < sbss_pkg::LimW'(diff)) ? lim[sbss_pkg::LevelW-1:0] : diff;

  // Bound the slope change around the previous slope
  assign old_x = sbss_pkg::BoundW'(state_i.slope);
  assign acc_x = signed'({2'b00, acc_lim_i});
  assign lim_o.bound = rising ? (old_x + acc_x) : (old_x - acc_x);

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for spectrum_bin_slew_smoother: streams bin requests,
// predicts each smoothed level and slope per bin, and checks every result in order.
// Depends on sbss_pkg and the block's RTL only.
`timescale 1ns / 1ps

// One smoothed result as it leaves the block
typedef struct {
  logic [sbss_pkg::BinW-1:0]          out_bin;
  logic [sbss_pkg::LevelW-1:0]        level;
  logic signed [sbss_pkg::SlopeW-1:0] slope;
} smoothed_t;

class slew_scoreboard;
  logic [sbss_pkg::RateW-1:0]         rise_rate;
  logic [sbss_pkg::RateW-1:0]         fall_rate;
  logic [sbss_pkg::RateW-1:0]         accel_rate;
  logic [sbss_pkg::LevelW-1:0]        level_mem [sbss_pkg::NumBinsDefault];
  logic signed [sbss_pkg::SlopeW-1:0] slope_mem [sbss_pkg::NumBinsDefault];
  smoothed_t                          expected_levels [$];
  int                                 requests;
  int                                 dropped;
  int                                 checked;
  int                                 errors;
  int                                 floor_hits;
  int                                 ceiling_hits;

  function new();
    rise_rate  = sbss_pkg::RateReset;
    fall_rate  = sbss_pkg::RateReset;
    accel_rate = sbss_pkg::RateReset;
    foreach (level_mem[i]) begin
      level_mem[i] = '0;
      slope_mem[i] = '0;
    end
  endfunction

  function void set_rate(logic [sbss_pkg::CfgIdxW-1:0] index,
                         logic [sbss_pkg::RateW-1:0] value);
    case (index)
      sbss_pkg::CfgRiseRate:  rise_rate  = value;
      sbss_pkg::CfgFallRate:  fall_rate  = value;
      sbss_pkg::CfgAccelRate: accel_rate = value;
      default: ;
    endcase
  endfunction

  function int pending();
    return expected_levels.size();
  endfunction

  // Scale a per-sample rate by the elapsed samples, dropping the 12 fraction bits
  function longint scaled_limit(logic [sbss_pkg::ElapW-1:0] elapsed,
                                logic [sbss_pkg::RateW-1:0] rate);
    longint product;
    product = longint'(elapsed) * longint'(rate);
    return product >> sbss_pkg::RateSh;
  endfunction

  // Advance one bin's level and slope for an accepted request
  function void note_request(logic [sbss_pkg::BinW-1:0] bin_idx,
                             logic [sbss_pkg::LevelW-1:0] magnitude,
                             logic [sbss_pkg::ElapW-1:0] elapsed, logic first_frame);
    longint    target;
    longint    cur;
    longint    prev;
    longint    accel;
    longint    bound;
    longint    change;
    longint    new_level;
    smoothed_t want;
    requests++;
    // Drop first-frame requests and bins past the end of the table
    if (first_frame || 32'(bin_idx) >= sbss_pkg::NumBinsDefault) begin
      dropped++;
      return;
    end
    target = longint'(magnitude);
    cur    = longint'(level_mem[bin_idx]);
    prev   = longint'(slope_mem[bin_idx]);
    accel  = scaled_limit(elapsed, accel_rate);
    if (target > cur) begin
      // Rise: clip to the attack limit, then cap how far the slope may climb
      bound  = scaled_limit(elapsed, rise_rate);
      change = (bound < target - cur) ? bound : target - cur;
      if (prev + accel < change) change = prev + accel;
    end else begin
      // Fall or hold: clip to the release limit, then cap how far the slope may drop
      bound  = scaled_limit(elapsed, fall_rate);
      change = (bound < cur - target) ? -bound : -(cur - target);
      if (prev - accel > change) change = prev - accel;
    end
    slope_mem[bin_idx] = change[sbss_pkg::SlopeW-1:0];
    // Floor the level at zero and saturate it at full scale
    new_level = cur + change;
    if (new_level < 0) begin
      new_level = 0;
      floor_hits++;
    end else if (new_level > longint'(sbss_pkg::LevelMax)) begin
      new_level = longint'(sbss_pkg::LevelMax);
      ceiling_hits++;
    end
    level_mem[bin_idx] = new_level[sbss_pkg::LevelW-1:0];
    want.out_bin = bin_idx;
    want.level   = new_level[sbss_pkg::LevelW-1:0];
    want.slope   = change[sbss_pkg::SlopeW-1:0];
    expected_levels.push_back(want);
  endfunction

  // Compare one accepted result with the oldest expectation
  function void check_result(logic [sbss_pkg::OutDataW-1:0] data);
    smoothed_t got;
    smoothed_t want;
    got.out_bin = data[sbss_pkg::BinW-1:0];
    got.level   = data[sbss_pkg::BinW +: sbss_pkg::LevelW];
    got.slope   = data[sbss_pkg::BinW+sbss_pkg::LevelW +: sbss_pkg::SlopeW];
    if (expected_levels.size() == 0) begin
      errors++;
      $display("%0t: unexpected result: expected none, actual bin %0d level %h slope %0d",
               $time, got.out_bin, got.level, got.slope);
      return;
    end
    want = expected_levels.pop_front();
    checked++;
    if (got.out_bin !== want.out_bin) begin
      errors++;
      $display("%0t: out_bin mismatch: expected %0d, actual %0d",
               $time, want.out_bin, got.out_bin);
    end
    if (got.level !== want.level) begin
      errors++;
      $display("%0t: level mismatch on bin %0d: expected %h, actual %h",
               $time, want.out_bin, want.level, got.level);
    end
    if (got.slope !== want.slope) begin
      errors++;
      $display("%0t: slope mismatch on bin %0d: expected %0d, actual %0d",
               $time, want.out_bin, want.slope, got.slope);
    end
  endfunction
endclass

module testbench;
  localparam int HalfPeriod    = 2;
  localparam int ResetCycles   = 11;
  localparam int PhaseCount    = 8;
  localparam int PhaseRequests = 200;
  localparam int SettleCycles  = 8;
  localparam int HoldCycles    = 300;
  localparam int DrainLimit    = 10000;
  localparam int RunLimitNs    = 2_000_000;

  logic                          clk       = 1'b0;
  logic                          rst_n     = 1'b0;
  logic [sbss_pkg::InDataW-1:0]  s_tdata   = '0;
  logic                          s_tuser   = 1'b0;
  logic                          s_tvalid  = 1'b0;
  logic                          s_tready;
  logic [sbss_pkg::OutDataW-1:0] m_tdata;
  logic                          m_tvalid;
  logic                          m_tready  = 1'b0;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [sbss_pkg::CfgIdxW-1:0]  cfg_index = sbss_pkg::CfgRiseRate;
  logic [sbss_pkg::RateW-1:0]    cfg_data  = '0;

  bit                            idle_on   = 1'b1;
  int                            sink_hold = 0;
  int                            settings  = 1;
  slew_scoreboard                sb        = new();

  spectrum_bin_slew_smoother i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  always #HalfPeriod clk = ~clk;

  // Mostly no gap, often a short one, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (!idle_on || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one request and hold it until the block takes it
  task automatic send_request(logic [sbss_pkg::BinW-1:0] bin_idx,
                              logic [sbss_pkg::LevelW-1:0] magnitude,
                              logic [sbss_pkg::ElapW-1:0] elapsed, logic first_frame);
    s_tdata  <= sbss_pkg::InDataW'({elapsed, magnitude, bin_idx});
    s_tuser  <= first_frame;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    sb.note_request(bin_idx, magnitude, elapsed, first_frame);
  endtask

  // Drop valid for a while, with junk on the data lines
  task automatic sender_gap(int cycles);
    if (cycles > 0) begin
      s_tvalid <= 1'b0;
      s_tdata  <= sbss_pkg::InDataW'({$urandom(), $urandom()});
      s_tuser  <= 1'($urandom_range(0, 1));
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Pause the sender until every expected result is back, then let drops flush
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(logic [sbss_pkg::CfgIdxW-1:0] index,
                           logic [sbss_pkg::RateW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.set_rate(index, value);
  endtask

  task automatic write_rates(logic [sbss_pkg::RateW-1:0] rise,
                             logic [sbss_pkg::RateW-1:0] fall,
                             logic [sbss_pkg::RateW-1:0] accel);
    write_reg(sbss_pkg::CfgRiseRate, rise);
    write_reg(sbss_pkg::CfgFallRate, fall);
    write_reg(sbss_pkg::CfgAccelRate, accel);
    cfg_valid <= 1'b0;
    settings++;
  endtask

  // Stream frames: runs of neighboring bins sharing one elapsed time, or scattered ones
  task automatic run_frames(int count, int hold_at);
    int                          sent;
    int                          frame_len;
    int                          k;
    int                          roll;
    bit                          scatter;
    logic [sbss_pkg::BinW-1:0]   bin_idx;
    logic [sbss_pkg::LevelW-1:0] magnitude;
    logic [sbss_pkg::ElapW-1:0]  elapsed;
    logic                        first_frame;
    sent = 0;
    while (sent < count) begin
      idle_on   = ($urandom_range(0, 3) != 0);
      scatter   = ($urandom_range(0, 7) == 0);
      frame_len = $urandom_range(1, 24);
      bin_idx   = ($urandom_range(0, 4) == 0)
                  ? sbss_pkg::BinW'($urandom_range(0, sbss_pkg::NumBinsDefault - 1))
                  : sbss_pkg::BinW'($urandom_range(0, 15));
      case ($urandom_range(0, 9))
        0:       elapsed = '0;
        1:       elapsed = '1;
        2, 3:    elapsed = sbss_pkg::ElapW'($urandom_range(0, 16'hFFFF));
        default: elapsed = sbss_pkg::ElapW'($urandom_range(1, 64));
      endcase
      for (k = 0; k < frame_len && sent < count; k++) begin
        roll = $urandom_range(0, 9);
        if (roll == 0) magnitude = '0;
        else if (roll == 1) magnitude = '1;
        else if (roll < 5) magnitude = sbss_pkg::LevelW'($urandom_range(0, sbss_pkg::LevelMax));
        else magnitude = sbss_pkg::LevelW'($urandom_range(0, 24'h03FFFF));
        // Broken frames jump between bins and elapsed times
        if (scatter) begin
          bin_idx = sbss_pkg::BinW'($urandom_range(0, sbss_pkg::NumBinsDefault - 1));
          elapsed = sbss_pkg::ElapW'($urandom());
        end
        first_frame = ($urandom_range(0, 19) == 0);
        send_request(bin_idx, magnitude, elapsed, first_frame);
        if (!first_frame) begin
          sent++;
          // Stall the receiver while the sender keeps pushing
          if (sent == hold_at) sink_hold = HoldCycles;
        end
        // Step to the next bin, now and then hitting the same one again
        if ($urandom_range(0, 7) != 0) bin_idx++;
        sender_gap(pick_gap());
      end
    end
  endtask

  // Accept results with random stalls and check each one
  initial begin : result_sink
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
      if (sink_hold > 0) begin
        m_tready <= 1'b0;
        sink_hold--;
      end else if (stall > 0) begin
        m_tready <= 1'b0;
        stall--;
      end else begin
        m_tready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  initial begin : stimulus
    int phase;
    int n;
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;

    // Directed requests at the reset rates (all limits wide open)
    send_request(9'd511, 24'hFFFFFF, 16'hFFFF, 1'b1);
    send_request(9'd0,   24'h000000, 16'h0000, 1'b0);
    send_request(9'd511, 24'hFFFFFF, 16'hFFFF, 1'b0);
    send_request(9'd511, 24'h000000, 16'hFFFF, 1'b0);
    // Rise with no time: slope stays deep negative, level floors at zero
    send_request(9'd511, 24'hFFFFFF, 16'h0000, 1'b0);
    send_request(9'd511, 24'hFFFFFF, 16'h0001, 1'b0);
    // Hold at full scale with a positive slope: level saturates at the top
    send_request(9'd7,   24'hFFFFFF, 16'hFFFF, 1'b0);
    send_request(9'd7,   24'hFFFFFF, 16'h0000, 1'b0);
    send_request(9'd7,   24'h000000, 16'h0001, 1'b0);
    send_request(9'd256, 24'h800000, 16'h8000, 1'b0);
    send_request(9'd255, 24'h7FFFFF, 16'h7FFF, 1'b0);
    send_request(9'd255, 24'h000000, 16'h0000, 1'b1);
    send_request(9'd255, 24'h7FFFFF, 16'h0000, 1'b0);
    send_request(9'd0,   24'h000001, 16'h0001, 1'b0);
    send_request(9'd0,   24'h000000, 16'h0001, 1'b0);
    send_request(9'd170, 24'h555555, 16'h5555, 1'b0);
    send_request(9'd341, 24'hAAAAAA, 16'hAAAA, 1'b0);

    for (phase = 0; phase < PhaseCount; phase++) begin
      // Reprogram the rates only once the pipeline is empty
      if (phase > 0) begin
        wait_drained();
        case (phase)
          1: write_rates('0, '0, '0);
          2: write_rates(sbss_pkg::RateReset, sbss_pkg::RateReset, sbss_pkg::RateReset);
          3: write_rates(sbss_pkg::RateW'($urandom_range(0, 65536)),
                         sbss_pkg::RateW'($urandom_range(0, 65536)),
                         sbss_pkg::RateW'($urandom_range(0, 16384)));
          4: write_rates(sbss_pkg::RateReset, '0,
                         sbss_pkg::RateW'($urandom_range(0, sbss_pkg::RateReset)));
          5: write_rates('0, sbss_pkg::RateReset,
                         sbss_pkg::RateW'($urandom_range(0, 4096)));
          6: write_rates(sbss_pkg::RateW'($urandom_range(0, sbss_pkg::RateReset)),
                         sbss_pkg::RateW'($urandom_range(0, sbss_pkg::RateReset)),
                         sbss_pkg::RateW'($urandom_range(0, sbss_pkg::RateReset)));
          default: write_rates(24'd1, 24'd1, 24'd1);
        endcase
      end
      if (phase == 2) begin
        run_frames(PhaseRequests, 60);
      end else if (phase == 4) begin
        run_frames(PhaseRequests / 2, -1);
        wait_drained();
        run_frames(PhaseRequests / 2, -1);
      end else begin
        run_frames(PhaseRequests, -1);
      end
    end

    // Let the last results drain, with a bound
    s_tvalid <= 1'b0;
    for (n = 0; n < DrainLimit && sb.pending() > 0; n++) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    if (sb.pending() > 0) begin
      sb.errors++;
      $display("%0t: %0d expected results never arrived", $time, sb.pending());
    end

    $display("summary: %0d requests (%0d first-frame drops), %0d results checked, %0d errors",
             sb.requests, sb.dropped, sb.checked, sb.errors);
    $display("summary: %0d rate settings, %0d zero-floor and %0d full-scale clamps",
             settings, sb.floor_hits, sb.ceiling_hits);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog
    #RunLimitNs;
    $display("tb: failure");
    $finish;
  end

endmodule
